// ===== hdl/rls3_pkg.sv =====
// ----------------------------------------------------------------------------
// rls3_pkg
// Shared types, constants and the per-channel sharpening function of the
// 3x3 laplacian sharpening filter.
// ----------------------------------------------------------------------------
package rls3_pkg;

   localparam int CHAN_W = 8;
   localparam int DIM_W  = 12;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;
   localparam logic [DIM_W-1:0]  MIN_DIM  = 12'd3;

   // request kinds
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   // csr indexes
   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      pixel_type px;
      logic      frame_end;
   } result_type;

   // clamped sum over the kernel in row-major order: north and west are
   // taken while the sum is still zero and clamp back to zero, so only
   // center, east and south remain
   function automatic logic [CHAN_W-1:0] sharpen_chan(
      input logic [CHAN_W-1:0] src,
      input logic [CHAN_W-1:0] center,
      input logic [CHAN_W-1:0] east,
      input logic [CHAN_W-1:0] south,
      input logic              interior
   );
      logic [CHAN_W:0]   dbl;
      logic [CHAN_W-1:0] acc;
      logic [CHAN_W-1:0] base;
      logic [CHAN_W:0]   sum;
      dbl  = {center, 1'b0};
      acc  = dbl[CHAN_W] ? CHAN_MAX : dbl[CHAN_W-1:0];
      acc  = (acc > east) ? acc - east : '0;
      acc  = (acc > south) ? acc - south : '0;
      base = interior ? acc : src;
      sum  = {1'b0, base} + {1'b0, src};
      return sum[CHAN_W] ? CHAN_MAX : sum[CHAN_W-1:0];
   endfunction

endpackage

// ===== hdl/rgb_laplacian_sharpen_3x3.sv =====
// ----------------------------------------------------------------------------
// rgb_laplacian_sharpen_3x3
// Streaming 3x3 laplacian sharpening of raster-order 24-bit rgb pixels with
// one line store, a two-stage datapath and a two-entry result queue.
// ----------------------------------------------------------------------------
//  channel   ports                                   direction
//  request   req_valid/req_ready, kind, red..blue    in
//  response  rsp_valid/rsp_ready, out_*, frame_end   out
//  csr       csr_we, csr_index, csr_wdata            in, write only
//
//  one request per clock while req_ready is high; a response passes through the
//  input register and line store read, then the result queue
//  pixel p of a frame comes out with input pixel p+W+1; W+1 flush requests
//  drain the last row, the one with frame_end restarts the position counters
//  req_ready drops only when the two-entry queue would overflow
//  synchronous reset restores 640x480 and clears all control state; the line
//  store needs no clearing since every entry is written before it is read
// ----------------------------------------------------------------------------
module rgb_laplacian_sharpen_3x3
   import rls3_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  logic [CHAN_W-1:0] req_red,
   input  logic [CHAN_W-1:0] req_green,
   input  logic [CHAN_W-1:0] req_blue,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CHAN_W-1:0] rsp_out_red,
   output logic [CHAN_W-1:0] rsp_out_green,
   output logic [CHAN_W-1:0] rsp_out_blue,
   output logic              rsp_frame_end,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [DIM_W-1:0]  csr_wdata
);

   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int CMP_W = ((AW > DIM_W) ? AW : DIM_W) + 1;

   // second stage control, one request per entry
   typedef struct packed {
      logic          pixel;     // writes line store and shifts window
      logic          result;    // pushes a response
      logic          use_mem;   // drain source read from line store
      logic          interior;
      logic          last;
      logic [AW-1:0] addr;
      pixel_type     px;
   } stage_type;

   // csr and position counters
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [AW-1:0]    in_col_ff, in_col_in;
   logic [DIM_W-1:0] in_row_ff, in_row_in;
   logic [AW-1:0]    out_col_ff, out_col_in;
   logic [DIM_W-1:0] out_row_ff, out_row_in;

   logic [DIM_W-1:0] eff_w;
   logic [DIM_W-1:0] eff_h;

   // line store holding the row above the input row
   pixel_type        line_ff [MAX_WIDTH];
   pixel_type        rd_data_ff;
   logic [AW-1:0]    rd_addr;

   // window taps that still matter: column read last from the line store
   // and the pixel taken last
   pixel_type        w_mid_ff;
   pixel_type        w_cur_ff;

   stage_type        s1_ff, s1_in;

   // result queue
   result_type       q_ff [2];
   logic             q_wr_ff, q_rd_ff;
   logic [1:0]       q_cnt_ff, q_cnt_in;
   logic [2:0]       q_occ;

   logic             accept, draining, is_flush, take_pixel, take_drain;
   logic             emit, result, interior, last;
   logic [CMP_W-1:0] w_ext, h_ext, in_col_ext, out_col_ext, out_row_ext;
   logic             push, pop;
   pixel_type        src;
   result_type       res;

   // effective frame size; height is 12 bits so only the lower clamp applies
   always_comb begin
      if (width_ff < MIN_DIM) begin
         eff_w = MIN_DIM;
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_w = DIM_W'(MAX_WIDTH);
      end else begin
         eff_w = width_ff;
      end
      eff_h = (height_ff < MIN_DIM) ? MIN_DIM : height_ff;
   end

   assign w_ext       = CMP_W'(eff_w);
   assign h_ext       = CMP_W'(eff_h);
   assign in_col_ext  = CMP_W'(in_col_ff);
   assign out_col_ext = CMP_W'(out_col_ff);
   assign out_row_ext = CMP_W'(out_row_ff);

   // ---------------- first stage: position bookkeeping ----------------
   assign accept     = req_valid && req_ready;
   assign draining   = in_row_ff >= eff_h;
   assign is_flush   = (req_kind == KIND_FLUSH);
   // a pixel after the frame is complete acts as a flush
   assign take_pixel = accept && !draining && !is_flush;
   assign take_drain = accept && draining;

   assign emit   = (in_row_ff >= 12'd2) || ((in_row_ff == 12'd1) && (in_col_ff != '0));
   assign result = take_drain || (take_pixel && emit);

   assign interior = (out_row_ff != '0) && (out_row_ext + CMP_W'(2) <= h_ext) &&
                     (out_col_ff != '0) && (out_col_ext + CMP_W'(2) <= w_ext);
   assign last     = (out_row_ext + CMP_W'(1) >= h_ext) &&
                     (out_col_ext + CMP_W'(1) >= w_ext);

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;

      if (take_pixel) begin
         if (in_col_ext + CMP_W'(1) >= w_ext) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 1'b1;
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
      end

      if (result) begin
         if (last) begin
            // frame done, next pixel starts a new frame
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else if (out_col_ext + CMP_W'(1) >= w_ext) begin
            out_col_in = '0;
            out_row_in = out_row_ff + 1'b1;
         end else begin
            out_col_in = out_col_ff + 1'b1;
         end
      end

      // csr write abandons the frame in progress
      if (csr_we) begin
         case (csr_index)
            CSR_WIDTH:  width_in  = csr_wdata;
            CSR_HEIGHT: height_in = csr_wdata;
            default:    ;
         endcase
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end
   end

   always_comb begin
      s1_in          = '0;
      s1_in.pixel    = take_pixel;
      s1_in.result   = result;
      s1_in.use_mem  = take_drain && (out_row_ext + CMP_W'(1) >= h_ext);
      s1_in.interior = take_pixel && interior;
      s1_in.last     = last;
      s1_in.addr     = in_col_ff;
      s1_in.px       = '{red: req_red, green: req_green, blue: req_blue};
   end

   // drain reads the last row back, pixels read the row above
   assign rd_addr = draining ? out_col_ff : in_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= 12'd640;
         height_ff  <= 12'd480;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         s1_ff      <= '0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         s1_ff      <= s1_in;
      end
   end

   // ---------------- line store ----------------
   always_ff @(posedge clock) begin
      rd_data_ff <= line_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (s1_ff.pixel) begin
         line_ff[s1_ff.addr] <= s1_ff.px;
      end
   end

   // ---------------- second stage: window and sharpening ----------------
   always_ff @(posedge clock) begin
      if (s1_ff.pixel) begin
         w_mid_ff <= rd_data_ff;
         w_cur_ff <= s1_ff.px;
      end
   end

   // center is the old middle tap, east the fresh read, south the old pixel
   always_comb begin
      src = (!s1_ff.pixel && s1_ff.use_mem) ? rd_data_ff : w_mid_ff;
      res.px.red   = sharpen_chan(src.red, w_mid_ff.red, rd_data_ff.red,
                                  w_cur_ff.red, s1_ff.interior);
      res.px.green = sharpen_chan(src.green, w_mid_ff.green, rd_data_ff.green,
                                  w_cur_ff.green, s1_ff.interior);
      res.px.blue  = sharpen_chan(src.blue, w_mid_ff.blue, rd_data_ff.blue,
                                  w_cur_ff.blue, s1_ff.interior);
      res.frame_end = s1_ff.last;
   end

   // ---------------- result queue ----------------
   assign push      = s1_ff.result;
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (q_cnt_ff != 2'd0);

   // room must remain for the request now in the second stage
   assign q_occ     = 3'(q_cnt_ff) + 3'(push) - 3'(pop);
   assign req_ready = (q_occ <= 3'd1);
   assign q_cnt_in  = 2'(q_occ);

   always_ff @(posedge clock) begin
      if (reset) begin
         q_cnt_ff <= '0;
         q_wr_ff  <= 1'b0;
         q_rd_ff  <= 1'b0;
      end else begin
         q_cnt_ff <= q_cnt_in;
         if (push) begin
            q_wr_ff <= ~q_wr_ff;
         end
         if (pop) begin
            q_rd_ff <= ~q_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[q_wr_ff] <= res;
      end
   end

   assign rsp_out_red   = q_ff[q_rd_ff].px.red;
   assign rsp_out_green = q_ff[q_rd_ff].px.green;
   assign rsp_out_blue  = q_ff[q_rd_ff].px.blue;
   assign rsp_frame_end = q_ff[q_rd_ff].frame_end;

endmodule

// ===== hdl/rls3_checker.sv =====
// ----------------------------------------------------------------------------
// rls3_checker
// Port-level checks of the sharpening filter, bound to the top level.
// ----------------------------------------------------------------------------
module rls3_checker
   import rls3_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CHAN_W-1:0] rsp_out_red,
   input logic [CHAN_W-1:0] rsp_out_green,
   input logic [CHAN_W-1:0] rsp_out_blue,
   input logic              rsp_frame_end
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
      $stable({rsp_out_red, rsp_out_green, rsp_out_blue, rsp_frame_end}))
      else $error("stalled response changed");

   // nothing left over from before reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a response only follows an accepted request that went through the second stage and the result queue
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without a request");

   // an empty queue never blocks requests
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty queue");

endmodule

bind rgb_laplacian_sharpen_3x3 rls3_checker u_rls3_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_red   (rsp_out_red),
   .rsp_out_green (rsp_out_green),
   .rsp_out_blue  (rsp_out_blue),
   .rsp_frame_end (rsp_frame_end)
);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rgb_laplacian_sharpen_3x3. Pixel and flush requests
// are queued per phase and driven over valid/ready while an in-bench model of
// the line stores, the 3x3 window and the position counters predicts every
// sharpened pixel. Phases cover the power-up sizes, a hand-picked 3x3 set,
// clamped and extreme sizes, and random frames under varying back-pressure.
// ----------------------------------------------------------------------------
module tb
   import rls3_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_W         = 2048;
   localparam int unsigned MAX_H         = 4095;
   localparam int unsigned PHASE_ITEMS   = 50;      // minimum requests per random phase
   localparam int unsigned SETTLE_CYCLES = 8;       // pipe is two deep, keep margin
   localparam int unsigned TAIL_CYCLES   = 20;
   localparam int unsigned HOLD_CYCLES   = 300;     // long response stall
   localparam int unsigned LIMIT         = 200000;

   typedef struct packed {
      logic      kind;
      pixel_type px;
   } pix_req_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // block ports, every input driven to a known value from time zero
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_kind  = KIND_PIXEL;
   logic [CHAN_W-1:0] req_red   = '0;
   logic [CHAN_W-1:0] req_green = '0;
   logic [CHAN_W-1:0] req_blue  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [CHAN_W-1:0] rsp_out_red;
   logic [CHAN_W-1:0] rsp_out_green;
   logic [CHAN_W-1:0] rsp_out_blue;
   logic              rsp_frame_end;
   logic              csr_we    = 1'b0;
   logic              csr_index = CSR_WIDTH;
   logic [DIM_W-1:0]  csr_wdata = '0;

   rgb_laplacian_sharpen_3x3 #(.MAX_WIDTH(MAX_W)) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_frame_end (rsp_frame_end),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // bench state
   pix_req_type pixel_feed_q[$];      // requests not yet offered
   result_type  sharpened_q[$];       // predicted pixels not yet seen
   pix_req_type cur_req;              // request currently on the port
   int unsigned n_queued     = 0;
   int unsigned n_errors     = 0;
   int unsigned cycle_count  = 0;
   int unsigned send_gap_pct = 0;
   int unsigned recv_gap_pct = 0;
   int unsigned hold_left    = 0;
   bit          squeeze_req  = 1'b0;
   bit          squeeze_done = 1'b0;

   // model of the filter: sizes, stores, window and position counters
   logic [DIM_W-1:0] cfg_width;
   logic [DIM_W-1:0] cfg_height;
   logic [23:0]      upper_rows [MAX_W];  // row two above the input row
   logic [23:0]      middle_rows[MAX_W];  // row one above the input row
   logic [23:0]      nbhd[9];             // 3x3 window, row-major
   int unsigned      in_col, in_row, out_col, out_row;

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      return (v < 3) ? 3 : ((v > hi) ? hi : v);
   endfunction

   // one channel: clamped running sum over the window, then saturating add
   // of the source pixel; border pixels just double the source
   function automatic logic [7:0] sharpen_byte(logic [23:0] src, bit interior, int sh);
      int acc, t, s, wt;
      s   = int'((src >> sh) & 24'hFF);
      acc = s;
      if (interior) begin
         acc = 0;
         for (int k = 0; k < 9; k++) begin
            wt  = (k == 4) ? 2 : ((k % 2 == 1) ? -1 : 0);
            t   = int'((nbhd[k] >> sh) & 24'hFF);
            acc = acc + wt * t;
            if (acc < 0) acc = 0;
            if (acc > 255) acc = 255;
         end
      end
      acc = acc + s;
      return (acc > 255) ? 8'hFF : acc[7:0];
   endfunction

   // advance the model by one accepted request, queue the pixel it releases
   task automatic predict_sharpen(input pix_req_type rq);
      int unsigned w, h, col;
      bit          draining, interior, emit, last_px;
      logic [23:0] src;
      result_type  res;
      w        = clamp_dim(cfg_width, MAX_W);
      h        = clamp_dim(cfg_height, MAX_H);
      draining = (in_row >= h);
      interior = 1'b0;
      // flush while the frame is still coming in does nothing
      if (!draining && rq.kind == KIND_FLUSH) return;
      if (!draining) begin
         col = (in_col >= w) ? 0 : in_col;
         for (int r = 0; r < 3; r++) begin
            nbhd[3*r]   = nbhd[3*r+1];
            nbhd[3*r+1] = nbhd[3*r+2];
         end
         nbhd[2]          = upper_rows[col];
         nbhd[5]          = middle_rows[col];
         nbhd[8]          = rq.px;
         upper_rows[col]  = middle_rows[col];
         middle_rows[col] = rq.px;
         emit = (in_row >= 2) || (in_row == 1 && col >= 1);
         if (col + 1 >= w) begin
            in_col = 0;
            in_row++;
         end else begin
            in_col = col + 1;
         end
         if (!emit) return;
         src      = nbhd[4];
         interior = out_row >= 1 && out_row + 2 <= h && out_col >= 1 && out_col + 2 <= w;
      end else if (out_row + 1 >= h && out_col < MAX_W) begin
         // draining the last row: pixel data is ignored
         src = middle_rows[out_col];
      end else begin
         src = nbhd[5];
      end
      last_px       = (out_row + 1 >= h) && (out_col + 1 >= w);
      res.px.red    = sharpen_byte(src, interior, 16);
      res.px.green  = sharpen_byte(src, interior, 8);
      res.px.blue   = sharpen_byte(src, interior, 0);
      res.frame_end = last_px;
      sharpened_q.push_back(res);
      if (last_px) begin
         in_col  = 0;
         in_row  = 0;
         out_col = 0;
         out_row = 0;
      end else if (out_col + 1 >= w) begin
         out_col = 0;
         out_row++;
      end else begin
         out_col++;
      end
   endtask

   task automatic flag_error(string msg);
      n_errors++;
      if (n_errors <= 10) $display("%0t ns: %s", $time, msg);
   endtask

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want)
         flag_error($sformatf("%s mismatch: expected %02h, got %02h", name, want, got));
   endtask

   // cycle counter and watchdog
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // request driver: offers the head of the feed queue, random gaps between
   // requests, payload frozen while valid is high
   always @(posedge clock) begin
      bit offering;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offering = req_valid;
         if (req_valid && req_ready) begin
            predict_sharpen(cur_req);
            offering = 1'b0;
         end
         if (!offering) begin
            if (pixel_feed_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               cur_req   = pixel_feed_q.pop_front();
               req_valid <= 1'b1;
               req_kind  <= cur_req.kind;
               req_red   <= cur_req.px.red;
               req_green <= cur_req.px.green;
               req_blue  <= cur_req.px.blue;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long response stall, counted here, started once on request
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (squeeze_req && !squeeze_done) begin
         hold_left    <= HOLD_CYCLES;
         squeeze_done <= 1'b1;
      end
   end

   // response monitor: every accepted pixel against the oldest prediction
   always @(posedge clock) begin
      result_type due;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (sharpened_q.size() == 0) begin
               flag_error($sformatf("unexpected response %02h %02h %02h frame_end %0b",
                  rsp_out_red, rsp_out_green, rsp_out_blue, rsp_frame_end));
            end else begin
               due = sharpened_q.pop_front();
               check_field("out_red", due.px.red, rsp_out_red);
               check_field("out_green", due.px.green, rsp_out_green);
               check_field("out_blue", due.px.blue, rsp_out_blue);
               check_field("frame_end", 8'(due.frame_end), 8'(rsp_frame_end));
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_gap_pct);
      end
   end

   // stimulus helpers
   function automatic logic [7:0] rand_chan();
      case ($urandom_range(3))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'($urandom_range(255));
         default: return 8'($urandom_range(8'h90, 8'h60));   // mid-range values
      endcase
   endfunction

   function automatic pixel_type rand_px();
      pixel_type p;
      p.red   = rand_chan();
      p.green = rand_chan();
      p.blue  = rand_chan();
      return p;
   endfunction

   task automatic push_req(logic kind, pixel_type px);
      pix_req_type rq;
      rq.kind = kind;
      rq.px   = px;
      pixel_feed_q.push_back(rq);
   endtask

   // one frame in raster order followed by its drain, stopped after cut
   // positions; noise flushes mid-frame and pixels mid-drain are sprinkled in
   task automatic push_frame(int unsigned w, int unsigned h, int unsigned cut);
      int unsigned n_px;
      n_px = w * h;
      for (int unsigned k = 0; k < cut; k++) begin
         if (k < n_px) begin
            if ($urandom_range(15) == 0) push_req(KIND_FLUSH, rand_px());
            push_req(KIND_PIXEL, rand_px());
         end else begin
            push_req(($urandom_range(7) == 0) ? KIND_PIXEL : KIND_FLUSH, rand_px());
         end
         n_queued++;
      end
      // flush right after frame_end: new frame not started yet, ignored
      if (cut == n_px + w + 1 && $urandom_range(7) == 0) push_req(KIND_FLUSH, rand_px());
   endtask

   // wait for every request to go in and every response to come out, then
   // give requests that produce nothing time to clear the pipe
   task automatic settle();
      while (pixel_feed_q.size() != 0 || req_valid || sharpened_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // size write while idle: counters restart, stores keep their contents
   task automatic write_reg(logic idx, logic [DIM_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_WIDTH) cfg_width = value;
      else cfg_height = value;
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // one configuration: random whole frames, sometimes an abandoned tail;
   // a nonzero cut sends a single partial frame instead
   task automatic run_phase(int unsigned w_raw, int unsigned h_raw, int unsigned cut);
      int unsigned w, h, full, start;
      write_reg(CSR_WIDTH, DIM_W'(w_raw));
      write_reg(CSR_HEIGHT, DIM_W'(h_raw));
      w    = clamp_dim(w_raw, MAX_W);
      h    = clamp_dim(h_raw, MAX_H);
      full = w * h + w + 1;
      @(negedge clock);
      if (cut != 0) begin
         push_frame(w, h, cut);
      end else begin
         start = n_queued;
         while (n_queued - start < PHASE_ITEMS) push_frame(w, h, full);
         if ($urandom_range(1) == 1) push_frame(w, h, $urandom_range(full - 1, 1));
      end
      settle();
   endtask

   // main sequence
   initial begin
      logic [23:0] dir_px[18];
      dir_px = '{24'h000000, 24'hFFFFFF, 24'h808080,
                 24'h7F7F7F, 24'hFF00FF, 24'h7F0180,
                 24'h123456, 24'h00FF00, 24'hFEDCBA,
                 24'h808080, 24'h000000, 24'hFFFFFF,
                 24'h010203, 24'h010203, 24'hFFFFFF,
                 24'h7F7F7F, 24'hFFFFFF, 24'h000000};

      // model at reset: 640x480, everything cleared
      cfg_width  = 12'd640;
      cfg_height = 12'd480;
      for (int i = 0; i < MAX_W; i++) begin
         upper_rows[i]  = '0;
         middle_rows[i] = '0;
      end
      for (int i = 0; i < 9; i++) nbhd[i] = '0;
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;

      // receiver mostly stalled, sender nearly always ready
      send_gap_pct = 13;
      recv_gap_pct = 70;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // power-up sizes: past the first row of 640 so pixels start to come out
      @(negedge clock);
      push_frame(640, 480, 660);
      settle();

      // hand-picked 3x3 frames: saturation and clamp-to-zero in the kernel,
      // flush before any pixel, pixel while draining, flush after frame end
      write_reg(CSR_WIDTH, 12'd3);
      write_reg(CSR_HEIGHT, 12'd3);
      @(negedge clock);
      push_req(KIND_FLUSH, 24'hFFFFFF);
      for (int k = 0; k < 9; k++) push_req(KIND_PIXEL, dir_px[k]);
      repeat (3) push_req(KIND_FLUSH, 24'h000000);
      push_req(KIND_PIXEL, 24'hA5A5A5);
      push_req(KIND_FLUSH, 24'h5A5A5A);
      for (int k = 9; k < 18; k++) push_req(KIND_PIXEL, dir_px[k]);
      repeat (4) push_req(KIND_FLUSH, 24'hFFFFFF);
      settle();

      // sizes below the minimum and small sizes, with a width above the maximum
      // abandoned early in its first row
      run_phase(0, 0, 0);
      run_phase(4, 3, 0);
      run_phase(4095, 3, 40);
      run_phase(5, 5, 0);

      // sender mostly idle, receiver nearly always ready
      send_gap_pct = 70;
      recv_gap_pct = 13;
      run_phase(8, 4, 0);
      run_phase(1, 2, 0);
      run_phase(3, 4095, 90);
      run_phase(16, 6, 0);

      // no idling at all; first phase gets the long response stall so the
      // result queue fills and the block pushes back on requests
      send_gap_pct = 0;
      recv_gap_pct = 0;
      squeeze_req  = 1'b1;
      run_phase(2, 7, 0);
      run_phase(11, 3, 0);
      run_phase(7, 9, 0);
      run_phase(6, 4, 0);

      repeat (TAIL_CYCLES) @(negedge clock);
      if (n_errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== rgb_laplacian_sharpen_3x3.f =====
hdl/rls3_pkg.sv
hdl/rgb_laplacian_sharpen_3x3.sv
hdl/rls3_checker.sv
bench/tb.sv
